@@ src/varint_length_prefix_deframer_unit_assert.svh @@
// Assertion helpers for the deframer; expect clk and arst_n in scope.
`ifndef VARINT_LENGTH_PREFIX_DEFRAMER_UNIT_ASSERT_SVH
`define VARINT_LENGTH_PREFIX_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VLPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked out of reset.
`define VLPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ src/vlpd_pkg.sv @@
package vlpd_pkg;

	// default widths and register reset
	localparam int LENGTH_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF  = 32;
	localparam int HDR_W            = 62;
	localparam logic [31:0] MAX_LEN_RESET = 32'd8388608;

	// input word kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [1:0] {
		ST_PAYLOAD    = 2'd0,
		ST_BAD_HEADER = 2'd1,
		ST_ABORTED    = 2'd2
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  payload_byte;
		logic        first_of_frame;
		logic        last_of_frame;
		logic [31:0] frame_length;
		logic [31:0] frame_number;
		status_t     status;
	} result_t;

endpackage

@@ src/vlpd_if.sv @@
// byte stream channel
interface vlpd_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, kind, data_byte, input ready);
	modport sink (input valid, kind, data_byte, output ready);
endinterface

// frame result channel
interface vlpd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        first_of_frame;
	logic        last_of_frame;
	logic [31:0] frame_length;
	logic [31:0] frame_number;
	logic [1:0]  status;

	modport source (output valid, payload_byte, first_of_frame, last_of_frame,
		frame_length, frame_number, status, input ready);
	modport sink (input valid, payload_byte, first_of_frame, last_of_frame,
		frame_length, frame_number, status, output ready);
endinterface

// max frame length register write channel
interface vlpd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ src/vlpd_parser.sv @@
`include "varint_length_prefix_deframer_unit_assert.svh"

module vlpd_parser
	import vlpd_pkg::*;
#(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  in_item_t    item,
	input  logic [31:0] max_len,
	output result_t     res
);

	localparam int PLEN_W = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;
	localparam logic [HDR_W-1:0] LEN_MASK = (HDR_W'(1) << LENGTH_WIDTH) - HDR_W'(1);
	localparam logic [HDR_W-1:0] FIELD_MAX = HDR_W'(32'hFFFF_FFFF);

	// parser state
	logic [HDR_W-1:0]       hv_q;
	logic [3:0]             need_q;
	logic [3:0]             seen_q;
	logic                   in_payload_q;
	logic [PLEN_W-1:0]      plen_q;
	logic [PLEN_W-1:0]      pseen_q;
	logic [COUNT_WIDTH-1:0] frames_q;

	logic [HDR_W-1:0]  hv_next;
	logic [HDR_W-1:0]  hv_sat;
	logic [3:0]        need_next;
	logic [3:0]        seen_next;
	logic              hdr_done;
	logic              hdr_bad;
	logic [PLEN_W:0]   pseen_inc;
	logic              last;

	// header accumulation, MSB first
	always_comb begin
		if (seen_q == 4'd0) begin
			hv_next = HDR_W'(item.data_byte[5:0]);
			case (item.data_byte[7:6])
				2'd0:    need_next = 4'd1;
				2'd1:    need_next = 4'd2;
				2'd2:    need_next = 4'd4;
				default: need_next = 4'd8;
			endcase
		end else begin
			hv_next   = {hv_q[HDR_W-9:0], item.data_byte};
			need_next = need_q;
		end
		seen_next = seen_q + 4'd1;
		hdr_done  = (seen_next >= need_next);
		hdr_bad   = (hv_next == '0) || (hv_next > HDR_W'(max_len)) || (hv_next > LEN_MASK);
		hv_sat    = (hv_next > LEN_MASK) ? LEN_MASK : hv_next;
	end

	// payload position
	assign pseen_inc = {1'b0, pseen_q} + (PLEN_W+1)'(1);
	assign last      = (pseen_inc >= {1'b0, plen_q});

	// result for the current word
	always_comb begin
		res                = '0;
		res.frame_number   = 32'(frames_q);
		res.frame_length   = 32'(plen_q);
		res.status         = ST_PAYLOAD;
		if (item.kind == KIND_END) begin
			res.valid  = in_payload_q;
			res.status = ST_ABORTED;
		end else if (in_payload_q) begin
			res.valid          = 1'b1;
			res.payload_byte   = item.data_byte;
			res.first_of_frame = (pseen_q == '0);
			res.last_of_frame  = last;
		end else if (hdr_done && hdr_bad) begin
			res.valid        = 1'b1;
			res.status       = ST_BAD_HEADER;
			res.frame_length = (hv_sat > FIELD_MAX) ? 32'hFFFF_FFFF : hv_sat[31:0];
		end
	end

	// state update when a word is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q         <= '0;
			need_q       <= '0;
			seen_q       <= '0;
			in_payload_q <= 1'b0;
			plen_q       <= '0;
			pseen_q      <= '0;
			frames_q     <= '0;
		end else if (step) begin
			if (item.kind == KIND_END) begin
				hv_q         <= '0;
				need_q       <= '0;
				seen_q       <= '0;
				in_payload_q <= 1'b0;
				plen_q       <= '0;
				pseen_q      <= '0;
			end else if (in_payload_q) begin
				if (last) begin
					frames_q     <= frames_q + COUNT_WIDTH'(1);
					in_payload_q <= 1'b0;
					plen_q       <= '0;
					pseen_q      <= '0;
				end else begin
					pseen_q <= pseen_inc[PLEN_W-1:0];
				end
			end else if (hdr_done) begin
				hv_q   <= '0;
				need_q <= '0;
				seen_q <= '0;
				if (!hdr_bad) begin
					in_payload_q <= 1'b1;
					plen_q       <= hv_next[PLEN_W-1:0];
					pseen_q      <= '0;
				end
			end else begin
				hv_q   <= hv_next;
				need_q <= need_next;
				seen_q <= seen_next;
			end
		end
	end

	`VLPD_ASSERT_NOW(a_no_header_in_payload, in_payload_q, seen_q == 4'd0, "header count live during payload")
	`VLPD_ASSERT_NOW(a_pos_below_len, in_payload_q, pseen_q < plen_q, "payload position past frame length")
	`VLPD_ASSERT_NEXT(a_frame_count, step && res.valid && res.last_of_frame && item.kind == KIND_DATA, frames_q == COUNT_WIDTH'($past(frames_q) + COUNT_WIDTH'(1)), "frame count not advanced on last byte")
	`VLPD_ASSERT_NOW(a_abort_only_in_payload, res.valid && res.status == ST_ABORTED, in_payload_q && item.kind == KIND_END, "abort reported outside a frame")

endmodule

@@ src/varint_length_prefix_deframer_unit.sv @@
// Channel  Role   Word
// bytes    sink   kind, data_byte: stream byte or stream end
// frames   source payload byte with first/last marks, length, frame number, status
// cfg      sink   max_frame_length register write, always ready
//
// One word per cycle sustained while no result is stalled; a word passes through
// the input register and the parser to the result register.
// The parser state update between input and result register sets the rate.
// Reset clears the parser, the frame count and sets max_frame_length to 8388608.
// A stall holds out_q and a full input register; bytes.ready follows frames.ready.
`include "varint_length_prefix_deframer_unit_assert.svh"

module varint_length_prefix_deframer_unit
	import vlpd_pkg::*;
#(
	parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	vlpd_in_if.sink     bytes,
	vlpd_out_if.source  frames,
	vlpd_cfg_if.sink    cfg
);

	logic        s1_valid_s1;
	in_item_t    item_s1;
	result_t     res;
	result_t     out_q;
	logic        out_valid_q;
	logic        advance;
	logic [31:0] max_len_q;

	// config register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg.valid) begin
			max_len_q <= cfg.data;
		end
	end

	// input register
	assign advance     = s1_valid_s1 && (!out_valid_q || frames.ready);
	assign bytes.ready = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			s1_valid_s1 <= 1'b1;
		end else if (advance) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1.kind      <= bytes.kind;
			item_s1.data_byte <= bytes.data_byte;
		end
	end

	// parser core
	vlpd_parser #(
		.LENGTH_WIDTH (LENGTH_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.max_len (max_len_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (frames.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign frames.valid          = out_valid_q;
	assign frames.payload_byte   = out_q.payload_byte;
	assign frames.first_of_frame = out_q.first_of_frame;
	assign frames.last_of_frame  = out_q.last_of_frame;
	assign frames.frame_length   = out_q.frame_length;
	assign frames.frame_number   = out_q.frame_number;
	assign frames.status         = out_q.status;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import vlpd_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_WORDS = 250;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [31:0] LEN_ALL = 32'hFFFF_FFFF;

	// one frame-channel word as the checker sees it
	typedef struct packed {
		logic [7:0]  pbyte;
		logic        first;
		logic        last;
		logic [31:0] flen;
		logic [31:0] fnum;
		status_t     st;
	} frame_word_t;

	// directed row: stream word plus an optional hand-written result
	typedef struct packed {
		in_item_t    item;
		logic        typed;
		logic        has;
		frame_word_t w;
	} dir_row_t;

	localparam frame_word_t NO_W = '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, ST_PAYLOAD};

	// directed stream, starting from the reset max length of 8388608
	dir_row_t dir_tab [24] = '{
		'{'{KIND_END,  8'hFF}, 1'b1, 1'b0, NO_W},
		'{'{KIND_DATA, 8'h00}, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd0, 32'd0, ST_BAD_HEADER}},
		'{'{KIND_DATA, 8'h01}, 1'b1, 1'b0, NO_W},
		'{'{KIND_DATA, 8'hFF}, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 32'd1, 32'd0, ST_PAYLOAD}},
		'{'{KIND_DATA, 8'h02}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'h00}, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd2, 32'd1, ST_PAYLOAD}},
		'{'{KIND_END,  8'h00}, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd2, 32'd1, ST_ABORTED}},
		'{'{KIND_DATA, 8'hC0}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'hFF}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'hFF}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'hFF}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'hFF}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'hFF}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'hFF}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'hFF}, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, LEN_ALL, 32'd1, ST_BAD_HEADER}},
		'{'{KIND_DATA, 8'h80}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'h80}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'h00}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'h01}, 1'b1, 1'b1,
			'{8'h00, 1'b0, 1'b0, 32'd8388609, 32'd1, ST_BAD_HEADER}},
		'{'{KIND_DATA, 8'h7F}, 1'b0, 1'b0, NO_W},
		'{'{KIND_END,  8'h5A}, 1'b1, 1'b0, NO_W},
		'{'{KIND_DATA, 8'h40}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'h01}, 1'b0, 1'b0, NO_W},
		'{'{KIND_DATA, 8'h00}, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 32'd1, 32'd1, ST_PAYLOAD}}
	};

	logic clk = 1'b0;
	logic arst_n;

	vlpd_in_if  byte_ch ();
	vlpd_out_if frame_ch ();
	vlpd_cfg_if cfg_ch ();

	varint_length_prefix_deframer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.frames (frame_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// parser mirror
	logic [61:0] hdr_val;
	int unsigned hdr_need;
	int unsigned hdr_seen;
	bit          in_pay;
	logic [31:0] pay_len;
	logic [31:0] pay_seen;
	logic [31:0] frames_done;
	logic [31:0] max_len;

	frame_word_t due_words [$];
	in_item_t    plan_q [$];
	int unsigned open_left;
	int          err_count;
	int          stall_cnt;
	bit          calm_src;
	bit          calm_snk;
	bit          hold_req;

	task automatic clear_parser();
		hdr_val  = '0;
		hdr_need = 0;
		hdr_seen = 0;
		in_pay   = 1'b0;
		pay_len  = '0;
		pay_seen = '0;
	endtask

	// advance the parser mirror by one stream word; at most one result
	task automatic deframe_word(input logic k, input logic [7:0] b,
			output bit has, output frame_word_t w);
		logic [63:0] v;
		bit          last;
		has = 1'b0;
		w   = NO_W;
		if (k == KIND_END) begin
			if (in_pay) begin
				has = 1'b1;
				w   = '{8'h00, 1'b0, 1'b0, pay_len, frames_done, ST_ABORTED};
			end
			clear_parser();
		end else if (in_pay) begin
			last = ({1'b0, pay_seen} + 33'd1) >= {1'b0, pay_len};
			has  = 1'b1;
			w    = '{b, pay_seen == 0, last, pay_len, frames_done, ST_PAYLOAD};
			pay_seen = pay_seen + 32'd1;
			if (last) begin
				frames_done = frames_done + 32'd1;
				clear_parser();
			end
		end else begin
			// header byte: top two bits of the first one pick 1/2/4/8 bytes
			if (hdr_seen == 0) begin
				hdr_need = 1 << b[7:6];
				hdr_val  = {56'd0, b[5:0]};
			end else begin
				hdr_val = {hdr_val[53:0], b};
			end
			hdr_seen++;
			if (hdr_seen >= hdr_need) begin
				v = {2'b00, hdr_val};
				if (v == 0 || v > {32'd0, max_len} || v > 64'hFFFF_FFFF) begin
					has = 1'b1;
					w   = '{8'h00, 1'b0, 1'b0, (v > 64'hFFFF_FFFF) ? LEN_ALL : v[31:0],
						frames_done, ST_BAD_HEADER};
					clear_parser();
				end else begin
					clear_parser();
					in_pay  = 1'b1;
					pay_len = v[31:0];
				end
			end
		end
	endtask

	// offer one stream word, predict once it is taken
	task automatic push_word(input in_item_t it, input bit typed, input bit t_has,
			input frame_word_t t_w);
		bit          has;
		frame_word_t w;
		@(negedge clk);
		while (!calm_src && $urandom_range(99) < 28) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.kind      <= it.kind;
		byte_ch.data_byte <= it.data_byte;
		do @(posedge clk); while (!byte_ch.ready);
		deframe_word(it.kind, it.data_byte, has, w);
		if (typed) begin
			has = t_has;
			w   = t_w;
		end
		if (has)
			due_words.push_back(w);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
	endtask

	// register write once the pipe has drained
	task automatic write_max(input logic [31:0] lim);
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= lim;
		do @(posedge clk); while (!cfg_ch.ready);
		max_len = lim;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic add_item(input logic k, input logic [7:0] b);
		plan_q.push_back('{k, b});
	endtask

	task automatic add_payload(input int unsigned cnt);
		repeat (cnt) add_item(KIND_DATA, 8'($urandom));
	endtask

	// header of random legal size, not always the shortest
	task automatic add_header(input logic [63:0] v);
		int unsigned sel;
		int unsigned n;
		logic [63:0] enc;
		sel = 0;
		if (v >= 64'd64)
			sel = 1;
		if (v >= 64'd16384)
			sel = 2;
		if (v >= 64'h4000_0000)
			sel = 3;
		sel = $urandom_range(3, sel);
		n   = 1 << sel;
		enc = v | (64'(sel) << (8 * n - 2));
		for (int i = n - 1; i >= 0; i--)
			add_item(KIND_DATA, enc[8 * i +: 8]);
	endtask

	// mostly whole frames, plus bad headers, cut frames, ends and noise
	task automatic plan_phase(input logic [31:0] lim, input int unsigned n);
		int unsigned roll;
		int unsigned cap;
		int unsigned len;
		int unsigned cnt;
		int unsigned sel;
		logic [63:0] v;
		add_payload(open_left);
		open_left = 0;
		while (plan_q.size() < n) begin
			roll = $urandom_range(99);
			if (roll < 68 && lim != 0) begin
				cap = ($urandom_range(19) == 0) ? 300 : 6;
				if (cap > lim)
					cap = lim;
				len = $urandom_range(cap, 1);
				add_header(len);
				add_payload(len);
			end else if (roll < 80) begin
				// length zero, just over the limit, or wider than 32 bits
				case ($urandom_range(2))
					0: v = 64'd0;
					1: v = (lim == LEN_ALL) ? {32'($urandom_range(32'h3FFF_FFFF, 1)), 32'($urandom)}
						: 64'(lim) + 64'd1 + 64'($urandom_range(500));
					default: v = {32'($urandom_range(32'h3FFF_FFFF, 1)), 32'($urandom)};
				endcase
				add_header(v);
			end else if (roll < 90) begin
				if ($urandom_range(1) && lim != 0) begin
					len = $urandom_range(lim, 1);
					cnt = $urandom_range(5);
					if (cnt >= len)
						cnt = len - 1;
					add_header(len);
					add_payload(cnt);
				end else begin
					sel = $urandom_range(3, 1);
					add_item(KIND_DATA, {2'(sel), 6'($urandom)});
					add_payload($urandom_range((1 << sel) - 2));
				end
				add_item(KIND_END, 8'($urandom));
			end else if (roll < 95) begin
				add_item(KIND_END, 8'($urandom));
			end else begin
				add_payload($urandom_range(3, 1));
				add_item(KIND_END, 8'($urandom));
			end
		end
		// sometimes leave a frame open so the next register write lands mid-frame
		if (lim >= 2 && $urandom_range(1)) begin
			cap = (lim > 6) ? 6 : lim;
			len = $urandom_range(cap, 2);
			add_header(len);
			add_payload(1);
			open_left = len - 1;
		end
	endtask

	task automatic send_plan();
		in_item_t it;
		while (plan_q.size() != 0) begin
			it = plan_q.pop_front();
			push_word(it, 1'b0, 1'b0, NO_W);
		end
		drop_valid();
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got);
		if (got !== want_v) begin
			$error("%s: expected %0h, actual %0h", name, want_v, got);
			err_count++;
		end
	endtask

	// result receiver: random stalls, one long hold-off on request
	initial begin
		frame_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				frame_ch.ready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				frame_ch.ready <= calm_snk || ($urandom_range(99) >= 28);
			end
		end
	end

	// compare each taken result with the oldest prediction
	always @(posedge clk) begin
		frame_word_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (due_words.size() == 0) begin
				$error("unexpected result: byte %0h status %0d", frame_ch.payload_byte,
					frame_ch.status);
				err_count++;
			end else begin
				want = due_words.pop_front();
				check_field("payload_byte", 32'(want.pbyte), 32'(frame_ch.payload_byte));
				check_field("first_of_frame", 32'(want.first), 32'(frame_ch.first_of_frame));
				check_field("last_of_frame", 32'(want.last), 32'(frame_ch.last_of_frame));
				check_field("frame_length", want.flen, frame_ch.frame_length);
				check_field("frame_number", want.fnum, frame_ch.frame_number);
				check_field("status", 32'(want.st), 32'(frame_ch.status));
			end
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			stall_cnt = 0;
		end else begin
			stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] lims [7];
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.kind      = KIND_DATA;
		byte_ch.data_byte = 8'h00;
		cfg_ch.valid      = 1'b0;
		cfg_ch.data       = 32'd0;
		calm_src          = 1'b0;
		calm_snk          = 1'b0;
		hold_req          = 1'b0;
		open_left         = 0;
		err_count         = 0;
		stall_cnt         = 0;
		clear_parser();
		frames_done = '0;
		max_len     = MAX_LEN_RESET;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed stream at the reset limit
		foreach (dir_tab[i])
			push_word(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].has, dir_tab[i].w);
		drop_valid();

		// random phases over a spread of limits, extremes included
		lims = '{32'd0, 32'd1, LEN_ALL, 32'd0, 32'd0, 32'd300, MAX_LEN_RESET};
		lims[3] = $urandom;
		lims[4] = $urandom_range(64, 2);
		foreach (lims[p]) begin
			write_max(lims[p]);
			calm_src = (p == 2);
			calm_snk = (p == 2);
			if (p == 4)
				hold_req = 1'b1;
			plan_phase(lims[p], PHASE_WORDS);
			send_plan();
		end

		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
